[sv/ldd_pkg.sv]
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared widths, constants and sequencer states of the load balanced dispatcher
// ----------------------------------------------------------------------------
package ldd_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned WORKER_W = 3;
  localparam int unsigned SEED_W   = 16;

  localparam logic [SEED_W-1:0] LFSR_POLY = 16'hB400;
  localparam logic [SEED_W-1:0] LFSR_INIT = 16'h0001;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_THR,
    ST_PIV,
    ST_CMP,
    ST_FALL,
    ST_ADV,
    ST_MUL,
    ST_PICK,
    ST_UPD
  } state_e;

endpackage

[sv/ldd_task_if.sv]
// ----------------------------------------------------------------------------
// ldd_task_if
// Valid/ready channel carrying one task item into the dispatcher
// ----------------------------------------------------------------------------
interface ldd_task_if;

  logic                         valid;
  logic                         ready;
  logic [ldd_pkg::KIND_W-1:0]   task_kind;
  logic [ldd_pkg::WEIGHT_W-1:0] task_weight;
  logic [ldd_pkg::SLOT_W-1:0]   param_slot;

  modport source (output valid, task_kind, task_weight, param_slot, input ready);
  modport sink   (input valid, task_kind, task_weight, param_slot, output ready);

endinterface

[sv/ldd_result_if.sv]
// ----------------------------------------------------------------------------
// ldd_result_if
// Valid/ready channel carrying one dispatch result item out of the dispatcher
// ----------------------------------------------------------------------------
interface ldd_result_if;

  logic                         valid;
  logic                         ready;
  logic [ldd_pkg::WORKER_W-1:0] worker;
  logic [ldd_pkg::KIND_W-1:0]   kind_out;
  logic [ldd_pkg::SLOT_W-1:0]   slot_out;
  logic                         used_median;

  modport source (output valid, worker, kind_out, slot_out, used_median, input ready);
  modport sink   (input valid, worker, kind_out, slot_out, used_median, output ready);

endinterface

[sv/load_balanced_dispatcher.sv]
// ----------------------------------------------------------------------------
// load_balanced_dispatcher
// Picks a lightly loaded worker for each task with an lfsr draw among
// candidates at most 0.8x mean load, else among those at most the upper median
//
//   channel     dir   handshake     payload
//   task_i      in    valid/ready   task_kind, task_weight, param_slot
//   result_o    out   valid/ready   worker, kind_out, slot_out, used_median
//   cfg_*       in    write enable  random seed (16 bits)
//
// per item: sum pass, threshold pass, lfsr step, draw, pick walk and update
// fallback adds a rank search over every pivot and a median candidate pass
// all of it runs through one counter read port and one shared compare/add
// reset clears all load counters and sets the lfsr to 1
// a result waits in the output register; the next item is taken meanwhile
// ----------------------------------------------------------------------------
module load_balanced_dispatcher #(
  parameter int unsigned WORKERS   = 8,
  parameter int unsigned LOAD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ldd_pkg::SEED_W-1:0] cfg_wdata_i,
  ldd_task_if.sink                   task_i,
  ldd_result_if.source               result_o
);

  localparam int unsigned IDXW   = $clog2(WORKERS);
  localparam int unsigned CNTW   = $clog2(WORKERS + 1);
  localparam int unsigned SUMW   = LOAD_BITS + $clog2(WORKERS);
  localparam int unsigned FIVE_W = 5 * WORKERS;
  localparam int unsigned PRODW  = LOAD_BITS + $clog2(FIVE_W + 1);
  localparam int unsigned RANK   = WORKERS / 2;
  localparam int unsigned MULW   = ldd_pkg::SEED_W + CNTW;

  localparam logic [IDXW-1:0]      LAST_IDX = IDXW'(WORKERS - 1);
  localparam logic [CNTW-1:0]      RANK_C   = CNTW'(RANK);
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

  ldd_pkg::state_e state_q, state_d;

  logic [LOAD_BITS-1:0]         load_q [WORKERS];
  logic [IDXW-1:0]              j_q, j_d, i_q, i_d;
  logic [SUMW-1:0]              sum_q, sum_d;
  logic [WORKERS-1:0]           cand_q, cand_d;
  logic [CNTW-1:0]              count_q, count_d;
  logic [LOAD_BITS-1:0]         pivot_q, pivot_d, med_q, med_d;
  logic [CNTW-1:0]              lt_q, lt_d, le_q, le_d;
  logic [ldd_pkg::SEED_W-1:0]   lfsr_q, lfsr_d;
  logic [CNTW-1:0]              k_q, k_d, seen_q, seen_d;
  logic [IDXW-1:0]              chosen_q, chosen_d;
  logic                         median_q, median_d;
  logic [ldd_pkg::WEIGHT_W-1:0] weight_q;
  logic [ldd_pkg::KIND_W-1:0]   kind_q;
  logic [ldd_pkg::SLOT_W-1:0]   slot_q;

  logic                         out_valid_q, out_valid_d;
  logic [ldd_pkg::WORKER_W-1:0] out_worker_q;
  logic [ldd_pkg::KIND_W-1:0]   out_kind_q;
  logic [ldd_pkg::SLOT_W-1:0]   out_slot_q;
  logic                         out_median_q;

  logic                 in_fire, out_fire, upd_fire, last_j, last_i, hit;
  logic [IDXW-1:0]      rd_idx;
  logic [LOAD_BITS-1:0] rd_data, room, new_load;
  logic [PRODW-1:0]     lhs, rhs;
  logic                 thr_pass;
  logic [CNTW-1:0]      count_nx, lt_nx, le_nx;
  logic [MULW-1:0]      draw;

  assign in_fire  = task_i.valid && task_i.ready;
  assign out_fire = result_o.valid && result_o.ready;
  assign upd_fire = (state_q == ldd_pkg::ST_UPD) && (!out_valid_q || result_o.ready);
  assign last_j   = (j_q == LAST_IDX);
  assign last_i   = (i_q == LAST_IDX);

  // single counter read port
  always_comb begin
    case (state_q)
      ldd_pkg::ST_PIV: rd_idx = i_q;
      ldd_pkg::ST_UPD: rd_idx = chosen_q;
      default:         rd_idx = j_q;
    endcase
  end
  assign rd_data = load_q[rd_idx];

  // shared compare/add unit
  assign lhs      = PRODW'(rd_data) * PRODW'(FIVE_W);
  assign rhs      = PRODW'({sum_q, 2'b00});
  assign thr_pass = (lhs <= rhs);
  assign count_nx = count_q + CNTW'(thr_pass);
  assign lt_nx    = lt_q + CNTW'(rd_data < pivot_q);
  assign le_nx    = le_q + CNTW'(rd_data <= pivot_q);
  assign hit      = cand_q[j_q] && (seen_q == k_q);
  assign room     = LOAD_MAX - rd_data;
  assign new_load = (LOAD_BITS'(weight_q) > room) ? LOAD_MAX
                                                  : rd_data + LOAD_BITS'(weight_q);
  assign draw     = MULW'(lfsr_q) * MULW'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldd_pkg::ST_IDLE: if (in_fire) state_d = ldd_pkg::ST_SUM;
      ldd_pkg::ST_SUM:  if (last_j) state_d = ldd_pkg::ST_THR;
      ldd_pkg::ST_THR: begin
        if (last_j) begin
          state_d = (count_nx == '0) ? ldd_pkg::ST_PIV : ldd_pkg::ST_ADV;
        end
      end
      ldd_pkg::ST_PIV:  state_d = ldd_pkg::ST_CMP;
      ldd_pkg::ST_CMP: begin
        if (last_j) state_d = last_i ? ldd_pkg::ST_FALL : ldd_pkg::ST_PIV;
      end
      ldd_pkg::ST_FALL: if (last_j) state_d = ldd_pkg::ST_ADV;
      ldd_pkg::ST_ADV:  state_d = ldd_pkg::ST_MUL;
      ldd_pkg::ST_MUL:  state_d = ldd_pkg::ST_PICK;
      ldd_pkg::ST_PICK: if (hit) state_d = ldd_pkg::ST_UPD;
      ldd_pkg::ST_UPD:  if (upd_fire) state_d = ldd_pkg::ST_IDLE;
      default:          state_d = ldd_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    j_d      = j_q;
    i_d      = i_q;
    sum_d    = sum_q;
    cand_d   = cand_q;
    count_d  = count_q;
    pivot_d  = pivot_q;
    med_d    = med_q;
    lt_d     = lt_q;
    le_d     = le_q;
    lfsr_d   = lfsr_q;
    k_d      = k_q;
    seen_d   = seen_q;
    chosen_d = chosen_q;
    median_d = median_q;
    case (state_q)
      ldd_pkg::ST_IDLE: begin
        j_d      = '0;
        sum_d    = '0;
        count_d  = '0;
        median_d = 1'b0;
        med_d    = '0;
        if (cfg_we_i) begin
          lfsr_d = (cfg_wdata_i == '0) ? ldd_pkg::LFSR_INIT : cfg_wdata_i;
        end
      end
      ldd_pkg::ST_SUM: begin
        sum_d = sum_q + SUMW'(rd_data);
        j_d   = last_j ? '0 : j_q + 1'b1;
      end
      ldd_pkg::ST_THR: begin
        cand_d[j_q] = thr_pass;
        count_d     = count_nx;
        j_d         = last_j ? '0 : j_q + 1'b1;
        if (last_j && count_nx == '0) begin
          median_d = 1'b1;
          i_d      = '0;
        end
      end
      ldd_pkg::ST_PIV: begin
        pivot_d = rd_data;
        lt_d    = '0;
        le_d    = '0;
        j_d     = '0;
      end
      ldd_pkg::ST_CMP: begin
        lt_d = lt_nx;
        le_d = le_nx;
        j_d  = last_j ? '0 : j_q + 1'b1;
        if (last_j) begin
          if (lt_nx <= RANK_C && RANK_C < le_nx) med_d = pivot_q;
          i_d = i_q + 1'b1;
        end
      end
      ldd_pkg::ST_FALL: begin
        cand_d[j_q] = (rd_data <= med_q);
        count_d     = count_q + CNTW'(rd_data <= med_q);
        j_d         = last_j ? '0 : j_q + 1'b1;
      end
      ldd_pkg::ST_ADV: begin
        lfsr_d = {1'b0, lfsr_q[ldd_pkg::SEED_W-1:1]}
               ^ (lfsr_q[0] ? ldd_pkg::LFSR_POLY : '0);
      end
      ldd_pkg::ST_MUL: begin
        k_d    = draw[ldd_pkg::SEED_W +: CNTW];
        seen_d = '0;
        j_d    = '0;
      end
      ldd_pkg::ST_PICK: begin
        if (hit) begin
          chosen_d = j_q;
        end else begin
          if (cand_q[j_q]) seen_d = seen_q + 1'b1;
          j_d = j_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire) out_valid_d = 1'b0;
    if (upd_fire) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldd_pkg::ST_IDLE;
      lfsr_q      <= ldd_pkg::LFSR_INIT;
      out_valid_q <= 1'b0;
      for (int w = 0; w < WORKERS; w++) begin
        load_q[w] <= '0;
      end
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
      if (upd_fire) load_q[chosen_q] <= new_load;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    i_q      <= i_d;
    sum_q    <= sum_d;
    cand_q   <= cand_d;
    count_q  <= count_d;
    pivot_q  <= pivot_d;
    med_q    <= med_d;
    lt_q     <= lt_d;
    le_q     <= le_d;
    k_q      <= k_d;
    seen_q   <= seen_d;
    chosen_q <= chosen_d;
    median_q <= median_d;
    if (in_fire) begin
      weight_q <= task_i.task_weight;
      kind_q   <= task_i.task_kind;
      slot_q   <= task_i.param_slot;
    end
    if (upd_fire) begin
      out_worker_q <= ldd_pkg::WORKER_W'(chosen_q);
      out_kind_q   <= kind_q;
      out_slot_q   <= slot_q;
      out_median_q <= median_q;
    end
  end

  assign task_i.ready         = (state_q == ldd_pkg::ST_IDLE);
  assign result_o.valid       = out_valid_q;
  assign result_o.worker      = out_worker_q;
  assign result_o.kind_out    = out_kind_q;
  assign result_o.slot_out    = out_slot_q;
  assign result_o.used_median = out_median_q;

`ifndef SYNTHESIS
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("lfsr reached zero");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ldd_pkg::ST_ADV |-> $countones(cand_q) == 32'(count_q))
    else $error("candidate count mismatch");

  a_draw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ldd_pkg::ST_PICK |-> k_q < count_q && cand_q != '0)
    else $error("draw outside candidate set");

  a_update_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> result_o.valid && state_q == ldd_pkg::ST_IDLE)
    else $error("update without result");
`endif

endmodule
